[rtl/sbc_pkg.sv]
// ----------------------------------------------------------------------------
// sbc_pkg: shared types and constants of the signed binomial coefficient unit
// datapath command codes, datapath status bundle, result status codes
// ----------------------------------------------------------------------------
package sbc_pkg;

  // default datapath width and fixed port width of the payload fields
  localparam int DATA_WIDTH_DEF = 64;
  localparam int IO_WIDTH       = 64;
  localparam int STATUS_WIDTH   = 2;

  // multiplier digit of the multiplier operand, quotient bits per divider cycle
  localparam int MUL_DIGIT = 16;
  localparam int DIV_RADIX = 4;

  localparam logic [STATUS_WIDTH-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_WIDTH-1:0] ST_OVERFLOW = 2'd2;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_ARGS,
    CMD_FOLD,
    CMD_SPAN,
    CMD_MUL_START,
    CMD_MUL,
    CMD_OVF,
    CMD_DIV_START,
    CMD_DIV,
    CMD_RESULT
  } cmd_t;

  typedef struct packed {
    logic early_done;
    logic loop_end;
    logic step_last;
    logic prod_ovf;
  } dp_status_t;

endpackage

[rtl/sbc_ctrl.sv]
// ----------------------------------------------------------------------------
// sbc_ctrl: sequencer of the signed binomial coefficient unit
// walks argument rewrite, fold, and the multiply/divide loop; owns handshakes
// ----------------------------------------------------------------------------
module sbc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  sbc_pkg::dp_status_t dp_status,
  output sbc_pkg::cmd_t       cmd
);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_ARGS   = 9'b000000010,
    S_FOLD   = 9'b000000100,
    S_SPAN   = 9'b000001000,
    S_CHECK  = 9'b000010000,
    S_MUL    = 9'b000100000,
    S_MCHK   = 9'b001000000,
    S_DIV    = 9'b010000000,
    S_FINISH = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   result_load;

  // result register is free once its item is taken
  assign result_load = (state_r == S_FINISH) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    cmd       = sbc_pkg::CMD_NONE;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd       = sbc_pkg::CMD_LOAD;
          state_nxt = S_ARGS;
        end
      end
      S_ARGS: begin
        cmd       = sbc_pkg::CMD_ARGS;
        state_nxt = dp_status.early_done ? S_FINISH : S_FOLD;
      end
      S_FOLD: begin
        cmd       = sbc_pkg::CMD_FOLD;
        state_nxt = S_SPAN;
      end
      S_SPAN: begin
        cmd       = sbc_pkg::CMD_SPAN;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (dp_status.loop_end) begin
          state_nxt = S_FINISH;
        end else begin
          cmd       = sbc_pkg::CMD_MUL_START;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd = sbc_pkg::CMD_MUL;
        if (dp_status.step_last) begin
          state_nxt = S_MCHK;
        end
      end
      S_MCHK: begin
        if (dp_status.prod_ovf) begin
          cmd       = sbc_pkg::CMD_OVF;
          state_nxt = S_FINISH;
        end else begin
          cmd       = sbc_pkg::CMD_DIV_START;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd = sbc_pkg::CMD_DIV;
        if (dp_status.step_last) begin
          state_nxt = S_CHECK;
        end
      end
      S_FINISH: begin
        if (result_load) begin
          cmd       = sbc_pkg::CMD_RESULT;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (result_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

[rtl/sbc_dp.sv]
// ----------------------------------------------------------------------------
// sbc_dp: datapath of the signed binomial coefficient unit
// argument rewrite, digit-serial multiplier, radix-16 small-divisor divider
// ----------------------------------------------------------------------------
module sbc_dp #(
  parameter int DATA_WIDTH = sbc_pkg::DATA_WIDTH_DEF
) (
  input  logic                              clk,
  input  sbc_pkg::cmd_t                     cmd,
  input  logic [DATA_WIDTH-1:0]             k_in,
  input  logic [DATA_WIDTH-1:0]             n_in,
  output sbc_pkg::dp_status_t               dp_status,
  output logic signed [DATA_WIDTH-1:0]      res,
  output logic [sbc_pkg::STATUS_WIDTH-1:0]  res_status
);

  localparam int W         = DATA_WIDTH;
  localparam int MD        = sbc_pkg::MUL_DIGIT;
  localparam int MUL_STEPS = (W + MD - 1) / MD;
  localparam int MUL_W     = MUL_STEPS * MD;
  localparam int ACC_W     = W + MUL_W;
  localparam int DR        = sbc_pkg::DIV_RADIX;
  localparam int DIV_STEPS = (W + DR - 1) / DR;
  localparam int DIV_PAD   = DIV_STEPS * DR;
  // the divisor i stays below W whenever a division is reached
  localparam int DIV_W     = $clog2(W) + 1;
  localparam int MAX_STEPS = (DIV_STEPS > MUL_STEPS) ? DIV_STEPS : MUL_STEPS;
  localparam int CNT_W     = $clog2(MAX_STEPS);
  localparam logic [W-1:0] TOP = {1'b0, {(W-1){1'b1}}};

  logic [W-1:0]       a_r, b_r, i_r, z_r;
  logic [MUL_W-1:0]   f_r;
  logic [ACC_W-1:0]   acc_r;
  logic [DIV_PAD-1:0] dq_r;
  logic [DIV_W-1:0]   rem_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               neg_r, ovf_r;
  logic signed [W-1:0] res_r;
  logic [sbc_pkg::STATUS_WIDTH-1:0] res_st_r;

  // argument rewrite
  logic         kneg, nneg, nltk;
  logic [W:0]   refl_sum;
  logic         early_done, early_ovf;
  logic [W-1:0] a_args, b_args;
  logic         neg_args;

  always_comb begin
    kneg       = a_r[W-1];
    nneg       = b_r[W-1];
    nltk       = $signed(b_r) < $signed(a_r);
    refl_sum   = {1'b0, a_r} + {1'b0, ~b_r};
    early_done = 1'b1;
    early_ovf  = 1'b0;
    a_args     = a_r;
    b_args     = b_r;
    neg_args   = 1'b0;
    if (!kneg && !nneg) begin
      early_done = nltk;
    end else if (!kneg && nneg) begin
      // k - n - 1 must fit the positive range
      if (refl_sum[W] || refl_sum[W-1]) begin
        early_ovf = 1'b1;
      end else begin
        early_done = 1'b0;
        b_args     = refl_sum[W-1:0];
        neg_args   = a_r[0];
      end
    end else if (kneg && nneg && !nltk) begin
      early_done = 1'b0;
      a_args     = ~b_r;
      b_args     = ~a_r;
      neg_args   = a_r[0] ^ b_r[0];
    end
  end

  // multiplier: one digit of f per cycle, top digit first
  logic [MD-1:0]    mul_digit;
  logic [W+MD-1:0]  pp;
  logic [ACC_W-1:0] acc_step;

  assign mul_digit = f_r[MUL_W-1 -: MD];
  assign pp        = (W+MD)'(z_r) * (W+MD)'(mul_digit);
  assign acc_step  = (acc_r << MD) + ACC_W'(pp);

  // divider: DR restoring steps per cycle on a narrow remainder
  logic [DIV_W-1:0]   divisor;
  logic [DIV_W:0]     rem_w;
  logic [DIV_W-1:0]   rem_step;
  logic [DIV_PAD-1:0] dq_step;

  assign divisor = i_r[DIV_W-1:0];

  always_comb begin
    rem_w   = {1'b0, rem_r};
    dq_step = dq_r;
    for (int j = 0; j < DR; j++) begin
      rem_w   = {rem_w[DIV_W-1:0], dq_step[DIV_PAD-1]};
      dq_step = dq_step << 1;
      if (rem_w >= {1'b0, divisor}) begin
        rem_w      = rem_w - {1'b0, divisor};
        dq_step[0] = 1'b1;
      end
    end
    rem_step = rem_w[DIV_W-1:0];
  end

  always_ff @(posedge clk) begin
    case (cmd)
      sbc_pkg::CMD_LOAD: begin
        a_r <= k_in;
        b_r <= n_in;
      end
      sbc_pkg::CMD_ARGS: begin
        a_r   <= a_args;
        b_r   <= b_args;
        neg_r <= neg_args;
        ovf_r <= early_ovf;
        z_r   <= '0;
      end
      sbc_pkg::CMD_FOLD: begin
        if (a_r > (b_r >> 1)) begin
          a_r <= b_r - a_r;
        end
      end
      sbc_pkg::CMD_SPAN: begin
        b_r <= b_r - a_r;
        i_r <= W'(1);
        z_r <= W'(1);
      end
      sbc_pkg::CMD_MUL_START: begin
        f_r   <= MUL_W'(i_r + b_r);
        acc_r <= '0;
        cnt_r <= CNT_W'(MUL_STEPS - 1);
      end
      sbc_pkg::CMD_MUL: begin
        acc_r <= acc_step;
        f_r   <= f_r << MD;
        cnt_r <= cnt_r - CNT_W'(1);
      end
      sbc_pkg::CMD_OVF: begin
        ovf_r <= 1'b1;
      end
      sbc_pkg::CMD_DIV_START: begin
        dq_r  <= DIV_PAD'(acc_r[W-1:0]);
        rem_r <= '0;
        cnt_r <= CNT_W'(DIV_STEPS - 1);
      end
      sbc_pkg::CMD_DIV: begin
        dq_r  <= dq_step;
        rem_r <= rem_step;
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          z_r <= dq_step[W-1:0];
          i_r <= i_r + W'(1);
        end
      end
      sbc_pkg::CMD_RESULT: begin
        if (ovf_r) begin
          res_r    <= '0;
          res_st_r <= sbc_pkg::ST_OVERFLOW;
        end else begin
          res_r    <= neg_r ? (W'(0) - z_r) : z_r;
          res_st_r <= sbc_pkg::ST_OK;
        end
      end
      default: begin
      end
    endcase
  end

  assign dp_status.early_done = early_done;
  assign dp_status.loop_end   = (i_r > a_r);
  assign dp_status.step_last  = (cnt_r == '0);
  assign dp_status.prod_ovf   = (acc_r > ACC_W'(TOP));

  assign res        = res_r;
  assign res_status = res_st_r;

endmodule

[rtl/signed_binomial_coefficient_unit.sv]
// ----------------------------------------------------------------------------
// signed_binomial_coefficient_unit: k-choose-n on signed integers
// extended rules for negative arguments, overflow flagged in the status field
// ----------------------------------------------------------------------------
// usage:
//   input item (in_valid/in_ready): in_choose_count = k, in_pool_size = n;
//   the low DATA_WIDTH bits of each are taken as two's complement.
//   result item (out_valid/out_ready): out_coefficient sign-extended to 64
//   bits, out_status 0 ok or 2 overflow (coefficient then 0).
// sequence: the arguments are loaded, rewritten and folded and the span is
//   formed; each loop step is then a check, a multiply pass, an overflow
//   check and a divide pass, then one closing check and the load of the
//   result register. the loop runs min(k, n-k) steps of the rewritten
//   arguments or stops at the first overflowing product, so at most 31 steps
//   at 64 bits, the last one cut short; the arguments alone can settle the
//   result with no loop. the 64x16 multiplier digit and the 4-bit-per-cycle
//   divider set the step length.
// throughput: one item at a time; the sequencer is ready again once the
//   previous one is in the result register, even if not yet delivered.
// a stalled receiver holds the result register; a finished item then waits
//   in the sequencer until the register is free.
// reset: synchronous, active low; the unit comes up empty and ready.
// ----------------------------------------------------------------------------
module signed_binomial_coefficient_unit #(
  parameter int DATA_WIDTH = sbc_pkg::DATA_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [sbc_pkg::IO_WIDTH-1:0]   in_choose_count,
  input  logic signed [sbc_pkg::IO_WIDTH-1:0]   in_pool_size,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [sbc_pkg::IO_WIDTH-1:0]   out_coefficient,
  output logic [sbc_pkg::STATUS_WIDTH-1:0]      out_status
);

  sbc_pkg::cmd_t                    cmd;
  sbc_pkg::dp_status_t              dp_status;
  logic signed [DATA_WIDTH-1:0]     res;
  logic [sbc_pkg::STATUS_WIDTH-1:0] res_status;

  sbc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .dp_status (dp_status),
    .cmd       (cmd)
  );

  sbc_dp #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk        (clk),
    .cmd        (cmd),
    .k_in       (in_choose_count[DATA_WIDTH-1:0]),
    .n_in       (in_pool_size[DATA_WIDTH-1:0]),
    .dp_status  (dp_status),
    .res        (res),
    .res_status (res_status)
  );

  assign out_coefficient = sbc_pkg::IO_WIDTH'(res);
  assign out_status      = res_status;

  // an accepted item keeps the sequencer busy for at least the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted again right after an accept");

  // only ok and overflow are ever reported
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == sbc_pkg::ST_OK) || (out_status == sbc_pkg::ST_OVERFLOW))
    else $error("unexpected status code");

  // overflow results carry a zero coefficient
  a_ovf_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == sbc_pkg::ST_OVERFLOW) |-> (out_coefficient == '0))
    else $error("overflow result with nonzero coefficient");

  // a result is loaded only into a free or draining output register
  a_result_load: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd == sbc_pkg::CMD_RESULT) |-> !out_valid || out_ready)
    else $error("result register overwritten before delivery");

endmodule
